[rtl/lattice_word_checksum_engine_macros.svh]
// assertion macros for the checksum engine
`ifndef LATTICE_WORD_CHECKSUM_ENGINE_MACROS_SVH
`define LATTICE_WORD_CHECKSUM_ENGINE_MACROS_SVH

// same-cycle implication
`define LWCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LWCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lwce_pkg.sv]
package lwce_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 40;
	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [4:0]  MOD_A_LAST = 5'd28;
	localparam logic [4:0]  MOD_B_LAST = 5'd30;

	typedef struct packed {
		logic load;
		logic crc_step;
		logic fold_step;
		logic emit;
	} lwce_cmd_t;

	typedef struct packed {
		logic last;
		logic total_zero;
	} lwce_stat_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
		logic [63:0] tmp;
		tmp = {v, v} << r;
		return tmp[63:32];
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h00_0000};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

[rtl/lwce_ctrl.sv]
`include "lattice_word_checksum_engine_macros.svh"

module lwce_ctrl
	import lwce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  lwce_stat_t stat,
	output lwce_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CRC  = 4'b0010,
		S_FOLD = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] crc_cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.crc_step  = 1'b0;
		cmd.fold_step = 1'b0;
		cmd.emit      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CRC;
				end
			end
			S_CRC: begin
				cmd.crc_step = 1'b1;
				if (crc_cnt_q == 2'd3) begin
					state_d = stat.last ? S_FOLD : S_EMIT;
				end
			end
			S_FOLD: begin
				if (stat.total_zero) begin
					state_d = S_EMIT;
				end else begin
					cmd.fold_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			crc_cnt_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				crc_cnt_q <= 2'd0;
			end else if (cmd.crc_step) begin
				crc_cnt_q <= crc_cnt_q + 2'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LWCE_ASSERT_NOW(a_emit_needs_room, clk, arst_n, cmd.emit, !out_valid_q || !out_stall, "emit while output register full")
	`LWCE_ASSERT_NEXT(a_load_starts_crc, clk, arst_n, cmd.load, state_q == S_CRC && crc_cnt_q == 2'd0, "accepted word did not start crc")
	`LWCE_ASSERT_NEXT(a_emit_sets_valid, clk, arst_n, cmd.emit, out_valid_q, "emitted word not shown")

endmodule

[rtl/lwce_dp.sv]
`include "lattice_word_checksum_engine_macros.svh"

module lwce_dp
	import lwce_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic [31:0] data_word,
	input  logic        last_word,
	input  lwce_cmd_t   cmd,
	output lwce_stat_t  stat,
	output logic [31:0] sum_mod29,
	output logic [31:0] sum_mod31,
	output logic [31:0] cksum_value,
	output logic        final_flag
);

	logic                   byte_rev_q;
	logic [31:0]            sum_a_q, sum_b_q;
	logic [4:0]             pos_a_q, pos_b_q;
	logic [31:0]            crc_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [31:0]            word_q;
	logic                   last_q;
	logic [31:0]            sum29_q, sum31_q, cksum_q;
	logic                   final_q;
	logic [31:0]            w_in;

	assign w_in = byte_rev_q ? swap32(data_word) : data_word;

	assign stat.last       = last_q;
	assign stat.total_zero = (total_q == '0);

	assign sum_mod29   = sum29_q;
	assign sum_mod31   = sum31_q;
	assign cksum_value = cksum_q;
	assign final_flag  = final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_rev_q <= 1'b0;
			sum_a_q    <= '0;
			sum_b_q    <= '0;
			pos_a_q    <= '0;
			pos_b_q    <= '0;
			crc_q      <= '0;
			total_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				byte_rev_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				sum_a_q <= sum_a_q ^ rotl32(w_in, pos_a_q);
				sum_b_q <= sum_b_q ^ rotl32(w_in, pos_b_q);
				pos_a_q <= (pos_a_q == MOD_A_LAST) ? 5'd0 : pos_a_q + 5'd1;
				pos_b_q <= (pos_b_q == MOD_B_LAST) ? 5'd0 : pos_b_q + 5'd1;
				total_q <= total_q + COUNT_WIDTH'(4);
			end else if (cmd.crc_step) begin
				crc_q <= crc_byte(crc_q, word_q[31:24]);
			end else if (cmd.fold_step) begin
				crc_q   <= crc_byte(crc_q, total_q[7:0]);
				total_q <= total_q >> 8;
			end else if (cmd.emit && last_q) begin
				sum_a_q <= '0;
				sum_b_q <= '0;
				pos_a_q <= '0;
				pos_b_q <= '0;
				crc_q   <= '0;
				total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= w_in;
			last_q <= last_word;
		end else if (cmd.crc_step) begin
			word_q <= word_q << 8;
		end
		if (cmd.emit) begin
			sum29_q <= sum_a_q;
			sum31_q <= sum_b_q;
			cksum_q <= last_q ? ~crc_q : 32'd0;
			final_q <= last_q;
		end
	end

	`LWCE_ASSERT_NOW(a_fold_nonzero, clk, arst_n, cmd.fold_step, total_q != '0, "fold step with empty count")
	`LWCE_ASSERT_NEXT(a_final_clears, clk, arst_n, cmd.emit && last_q, sum_a_q == '0 && crc_q == '0 && total_q == '0, "state not cleared after final word")

endmodule

[rtl/lattice_word_checksum_engine.sv]
// Word checksum engine: each accepted 32-bit word (byte-swapped first when
// byte_reverse is set) is folded into two rotating xor sums, rotation cycling
// mod 29 and mod 31, and into a posix cksum crc-32 one byte per cycle. A word
// is accepted, then passes through four crc byte steps, then loads the output
// register once that register is free. A word with last_word set also folds
// the byte count into the crc least significant byte first, one byte a cycle,
// until the remaining count is zero; cksum_value then carries the complemented
// crc, final_flag is set and all sums and counts clear. The result sits in an
// output register, so the next word is taken while it waits; byte_reverse
// keeps its value across streams.

module lattice_word_checksum_engine
	import lwce_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sum_mod29,
	output logic [31:0] sum_mod31,
	output logic [31:0] cksum_value,
	output logic        final_flag
);

	lwce_cmd_t  cmd;
	lwce_stat_t stat;

	lwce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lwce_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_word   (data_word),
		.last_word   (last_word),
		.cmd         (cmd),
		.stat        (stat),
		.sum_mod29   (sum_mod29),
		.sum_mod31   (sum_mod31),
		.cksum_value (cksum_value),
		.final_flag  (final_flag)
	);

endmodule
